[src/slcfp_pkg.sv]
// ---------------------------------------------------------------------------
// slcfp_pkg
// Shared constants of the sync/length/checksum frame parser.
// ---------------------------------------------------------------------------
`default_nettype none

package slcfp_pkg;

  // payload buffer
  localparam int unsigned BUFFER_DEPTH = 32;
  localparam int unsigned ADDR_W       = $clog2(BUFFER_DEPTH);

  // field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned IDX_W  = 5;

  // configuration port
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_SYNC_FIRST   = 2'd0,
    REG_SYNC_SECOND  = 2'd1,
    REG_LENGTH_LIMIT = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_e;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST   = 8'd90;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST  = 8'd165;
  localparam logic [LEN_W-1:0]  LENGTH_LIMIT_RST = 6'd32;

endpackage

`default_nettype wire

[src/slcfp_rx_if.sv]
// ---------------------------------------------------------------------------
// slcfp_rx_if
// Received byte channel: valid/ready with one byte of payload.
// ---------------------------------------------------------------------------
`default_nettype none

interface slcfp_rx_if;
  logic                        valid;
  logic                        ready;
  logic [slcfp_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[src/slcfp_res_if.sv]
// ---------------------------------------------------------------------------
// slcfp_res_if
// Result channel: one good frame's payload byte, or an empty frame's result.
// ---------------------------------------------------------------------------
`default_nettype none

interface slcfp_res_if;
  logic                         valid;
  logic                         ready;
  logic [slcfp_pkg::BYTE_W-1:0] command;
  logic [slcfp_pkg::LEN_W-1:0]  payload_length;
  logic [slcfp_pkg::IDX_W-1:0]  byte_index;
  logic [slcfp_pkg::BYTE_W-1:0] data_byte;
  logic                         has_data;
  logic                         last;

  modport source (output valid, output command, output payload_length, output byte_index,
                  output data_byte, output has_data, output last, input ready);
  modport sink   (input valid, input command, input payload_length, input byte_index,
                  input data_byte, input has_data, input last, output ready);
endinterface

`default_nettype wire

[src/slcfp_ram.sv]
// ---------------------------------------------------------------------------
// slcfp_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module slcfp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/sync_length_checksum_frame_parser.sv]
// ---------------------------------------------------------------------------
// sync_length_checksum_frame_parser
// Hunts for two sync bytes, takes length, command, payload and a sum
// checksum, and replays each good frame's payload from a buffer RAM.
// ---------------------------------------------------------------------------
//
//  channel  dir  handshake          payload
//  rx_i     in   valid/ready        rx_byte
//  res_o    out  valid/ready        command, payload_length, byte_index,
//                                   data_byte, has_data, last
//  apb      in   psel/penable/...   3 registers at paddr 0, 4, 8
//
// one received byte is taken per cycle while a frame is being parsed.
// after a good checksum with payload, input is held off while the buffer
// RAM is replayed through its single registered read port: one result per
// cycle while the output register is free.
// a frame without payload gives its one result straight from the checksum.
// reset is asynchronous; the buffer RAM needs no clearing.
// a stalled result holds in the output register; parsing carries on up to
// the next checksum byte, which waits until the register is free.
// ---------------------------------------------------------------------------
`default_nettype none

module sync_length_checksum_frame_parser (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  slcfp_rx_if.sink                                rx_i,
  slcfp_res_if.source                             res_o,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [slcfp_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [slcfp_pkg::PDATA_W-1:0]      pwdata,
  output logic      [slcfp_pkg::PDATA_W-1:0]      prdata,
  output logic                                    pready
);

  localparam int unsigned BW = slcfp_pkg::BYTE_W;
  localparam int unsigned LW = slcfp_pkg::LEN_W;
  localparam int unsigned AW = slcfp_pkg::ADDR_W;
  localparam int unsigned IW = slcfp_pkg::IDX_W;

  localparam logic [2:0] PH_SYNC1 = 3'd0;
  localparam logic [2:0] PH_SYNC2 = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_CMD   = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_CSUM  = 3'd5;

  // configuration registers
  logic [BW-1:0] sync_first_q, sync_second_q;
  logic [LW-1:0] length_limit_q;
  slcfp_pkg::reg_idx_e cfg_idx;
  logic          cfg_we;

  assign pready  = 1'b1;
  assign cfg_idx = slcfp_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q   <= slcfp_pkg::SYNC_FIRST_RST;
      sync_second_q  <= slcfp_pkg::SYNC_SECOND_RST;
      length_limit_q <= slcfp_pkg::LENGTH_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        slcfp_pkg::REG_SYNC_FIRST:   sync_first_q   <= pwdata[BW-1:0];
        slcfp_pkg::REG_SYNC_SECOND:  sync_second_q  <= pwdata[BW-1:0];
        slcfp_pkg::REG_LENGTH_LIMIT: length_limit_q <= pwdata[LW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      slcfp_pkg::REG_SYNC_FIRST:   prdata = {{(slcfp_pkg::PDATA_W-BW){1'b0}}, sync_first_q};
      slcfp_pkg::REG_SYNC_SECOND:  prdata = {{(slcfp_pkg::PDATA_W-BW){1'b0}}, sync_second_q};
      slcfp_pkg::REG_LENGTH_LIMIT: prdata = {{(slcfp_pkg::PDATA_W-LW){1'b0}}, length_limit_q};
      default:                     prdata = '0;
    endcase
  end

  // parser and replay state
  logic [2:0]    phase_q, phase_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] fill_q, fill_d;
  logic [BW-1:0] sum_q, sum_d;
  logic [BW-1:0] cmd_q, cmd_d;
  logic          replay_q, replay_d;
  logic [LW-1:0] rd_idx_q, rd_idx_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] pend_idx_q, pend_idx_d;

  // output register
  logic          out_valid_q, out_valid_d;
  logic [BW-1:0] out_cmd_q, out_cmd_d;
  logic [LW-1:0] out_len_q, out_len_d;
  logic [IW-1:0] out_idx_q, out_idx_d;
  logic [BW-1:0] out_data_q, out_data_d;
  logic          out_has_q, out_has_d;
  logic          out_last_q, out_last_d;

  // ram ports
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [BW-1:0] ram_rdata;

  logic          in_ready, in_fire, out_free, load, issue;
  logic [BW-1:0] b;
  logic [LW-1:0] limit;
  logic [LW-1:0] fill_inc;
  logic [BW-1:0] resync;

  assign b        = rx_i.rx_byte;
  assign out_free = !out_valid_q || res_o.ready;
  // a good empty frame writes the output register at the checksum
  assign in_ready = !replay_q && !(phase_q == PH_CSUM && !out_free);
  assign in_fire  = rx_i.valid && in_ready;
  assign limit    = (length_limit_q > LW'(slcfp_pkg::BUFFER_DEPTH))
                    ? LW'(slcfp_pkg::BUFFER_DEPTH) : length_limit_q;
  assign fill_inc = fill_q + LW'(1);
  assign resync   = sum_q - BW'(1);

  always_comb begin
    phase_d     = phase_q;
    len_d       = len_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    cmd_d       = cmd_q;
    replay_d    = replay_q;
    rd_idx_d    = rd_idx_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    out_valid_d = out_valid_q;
    out_cmd_d   = out_cmd_q;
    out_len_d   = out_len_q;
    out_idx_d   = out_idx_q;
    out_data_d  = out_data_q;
    out_has_d   = out_has_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_waddr   = fill_q[AW-1:0];
    ram_re      = 1'b0;
    ram_raddr   = rd_idx_q[AW-1:0];
    load        = 1'b0;
    issue       = 1'b0;

    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (in_fire) begin
      unique case (phase_q)
        PH_SYNC1: begin
          if (b == sync_first_q) phase_d = PH_SYNC2;
        end
        PH_SYNC2: begin
          if (b == sync_second_q) phase_d = PH_LEN;
          else if (b != sync_first_q) phase_d = PH_SYNC1;
        end
        PH_LEN: begin
          if (b > {{(BW-LW){1'b0}}, limit}) begin
            phase_d = (b == sync_first_q) ? PH_SYNC2 : PH_SYNC1;
          end else begin
            len_d   = b[LW-1:0];
            sum_d   = b;
            fill_d  = '0;
            phase_d = PH_CMD;
          end
        end
        PH_CMD: begin
          cmd_d   = b;
          sum_d   = sum_q + b;
          phase_d = (len_q == '0) ? PH_CSUM : PH_DATA;
        end
        PH_DATA: begin
          ram_we = (fill_q < LW'(slcfp_pkg::BUFFER_DEPTH));
          fill_d = fill_inc;
          sum_d  = sum_q + b;
          if (fill_inc >= len_q) phase_d = PH_CSUM;
        end
        PH_CSUM: begin
          if (b == resync) begin
            phase_d = PH_SYNC1;
            if (len_q == '0) begin
              out_valid_d = 1'b1;
              out_cmd_d   = cmd_q;
              out_len_d   = len_q;
              out_idx_d   = '0;
              out_data_d  = '0;
              out_has_d   = 1'b0;
              out_last_d  = 1'b1;
            end else begin
              replay_d = 1'b1;
              rd_idx_d = '0;
            end
          end else begin
            phase_d = (b == sync_first_q) ? PH_SYNC2 : PH_SYNC1;
          end
        end
        default: phase_d = PH_SYNC1;
      endcase
    end

    if (replay_q) begin
      load = pend_q && out_free;
      if (load) begin
        out_valid_d = 1'b1;
        out_cmd_d   = cmd_q;
        out_len_d   = len_q;
        out_idx_d   = IW'(pend_idx_q);
        out_data_d  = ram_rdata;
        out_has_d   = 1'b1;
        out_last_d  = (LW'(pend_idx_q) + LW'(1)) == len_q;
        pend_d      = 1'b0;
        if ((LW'(pend_idx_q) + LW'(1)) == len_q) replay_d = 1'b0;
      end
      // next read goes out as soon as the read data register is freed
      issue = (rd_idx_q < len_q) && (!pend_q || load);
      if (issue) begin
        ram_re     = 1'b1;
        pend_d     = 1'b1;
        pend_idx_d = rd_idx_q[AW-1:0];
        rd_idx_d   = rd_idx_q + LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SYNC1;
      len_q       <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      cmd_q       <= '0;
      replay_q    <= 1'b0;
      rd_idx_q    <= '0;
      pend_q      <= 1'b0;
      pend_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      len_q       <= len_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      cmd_q       <= cmd_d;
      replay_q    <= replay_d;
      rd_idx_q    <= rd_idx_d;
      pend_q      <= pend_d;
      pend_idx_q  <= pend_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_cmd_q  <= out_cmd_d;
    out_len_q  <= out_len_d;
    out_idx_q  <= out_idx_d;
    out_data_q <= out_data_d;
    out_has_q  <= out_has_d;
    out_last_q <= out_last_d;
  end

  slcfp_ram #(
    .WIDTH (BW),
    .DEPTH (slcfp_pkg::BUFFER_DEPTH)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (b),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rx_i.ready           = in_ready;
  assign res_o.valid          = out_valid_q;
  assign res_o.command        = out_cmd_q;
  assign res_o.payload_length = out_len_q;
  assign res_o.byte_index     = out_idx_q;
  assign res_o.data_byte      = out_data_q;
  assign res_o.has_data       = out_has_q;
  assign res_o.last           = out_last_q;

  // no byte is taken while the buffer is being replayed
  a_replay_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    replay_q |-> !rx_i.ready)
    else $error("byte request accepted during replay");

  // read data waiting with a free output register is loaded next edge
  a_pending_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (replay_q && pend_q && !out_valid_q) |=> out_valid_q)
    else $error("pending read data not loaded");

  // last on a data result sits on the final payload byte
  a_last_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_has_q && out_last_q)
      |-> ((LW'(out_idx_q) + LW'(1)) == out_len_q))
    else $error("last marked on wrong byte");

  // the read pointer never passes the frame length
  a_read_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    replay_q |-> (rd_idx_q <= len_q))
    else $error("replay read beyond frame");

endmodule

`default_nettype wire
